/* src/lpfl_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the length-prefixed frame loader.
// Used by lpfl_front, lpfl_queue, lpfl_back and the top level.
package lpfl_pkg;

	localparam int ADDR_BITS_DEF = 17;
	localparam int QUEUE_DEPTH   = 2;

	localparam int LEN_LIMIT_W   = 18;
	localparam int LOAD_BASE_W   = 17;
	localparam int CFG_DATA_W    = 18;
	localparam int CFG_INDEX_W   = 1;
	localparam int WADDR_W       = 17;
	localparam int INDEX_W       = 18;
	localparam int LENGTH_W      = 32;

	localparam logic [CFG_INDEX_W-1:0] REG_LEN_LIMIT = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_LOAD_BASE = 1'd1;

	localparam logic [LEN_LIMIT_W-1:0] LEN_LIMIT_RST = 18'd88576;
	localparam logic [LOAD_BASE_W-1:0] LOAD_BASE_RST = 17'h00400;

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_PAYLOAD = 2'd1,
		PH_CHECK   = 2'd2,
		PH_DONE    = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		ST_WAIT = 2'd0,
		ST_RECV = 2'd1,
		ST_OK   = 2'd2,
		ST_BAD  = 2'd3
	} status_t;

	// One classified byte, handed from the front to the back.
	typedef struct packed {
		logic                we;
		logic [7:0]          data;
		logic [INDEX_W-1:0]  index;
		status_t             status;
		logic                start;
	} q_entry_t;

endpackage

/* src/lpfl_front.sv */
`timescale 1ns / 1ps
// Front end: accepts received bytes, tracks the frame state and classifies each byte.
// Depends on lpfl_pkg.
module lpfl_front
	import lpfl_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [7:0]             rx_byte,
	input  logic [LEN_LIMIT_W-1:0] len_limit,
	input  logic                   queue_full,
	output logic                   push,
	output q_entry_t               push_entry
);

	phase_t              phase_q, phase_n;
	logic [1:0]          header_count_q, header_count_n;
	logic [LENGTH_W-1:0] frame_length_q, frame_length_n;
	logic [INDEX_W-1:0]  payload_index_q, payload_index_n;
	logic [7:0]          running_sum_q, running_sum_n;
	status_t             final_status_q, final_status_n;

	assign in_ready = !queue_full;
	assign push     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_HEADER;
			header_count_q  <= 2'd0;
			frame_length_q  <= '0;
			payload_index_q <= '0;
			running_sum_q   <= 8'd0;
			final_status_q  <= ST_WAIT;
		end else if (push) begin
			phase_q         <= phase_n;
			header_count_q  <= header_count_n;
			frame_length_q  <= frame_length_n;
			payload_index_q <= payload_index_n;
			running_sum_q   <= running_sum_n;
			final_status_q  <= final_status_n;
		end
	end

	always_comb begin
		phase_n         = phase_q;
		header_count_n  = header_count_q;
		frame_length_n  = frame_length_q;
		payload_index_n = payload_index_q;
		running_sum_n   = running_sum_q;
		final_status_n  = final_status_q;
		push_entry      = '0;
		case (phase_q)
			PH_HEADER: begin
				frame_length_n = frame_length_q
					| (LENGTH_W'(rx_byte) << {header_count_q, 3'b000});
				header_count_n = header_count_q + 2'd1;
				if (header_count_q == 2'd3) begin
					if (frame_length_n >= LENGTH_W'(len_limit)) begin
						phase_n        = PH_DONE;
						final_status_n = ST_BAD;
					end else begin
						phase_n        = (frame_length_n == '0) ? PH_CHECK : PH_PAYLOAD;
						final_status_n = ST_RECV;
					end
				end
			end
			PH_PAYLOAD: begin
				push_entry.we    = 1'b1;
				push_entry.data  = rx_byte;
				push_entry.index = payload_index_q;
				running_sum_n    = running_sum_q + rx_byte;
				payload_index_n  = payload_index_q + INDEX_W'(1);
				if (LENGTH_W'(payload_index_n) >= frame_length_q) begin
					phase_n = PH_CHECK;
				end
			end
			PH_CHECK: begin
				phase_n = PH_DONE;
				if (rx_byte == running_sum_q) begin
					final_status_n   = ST_OK;
					push_entry.start = 1'b1;
				end else begin
					final_status_n = ST_BAD;
				end
			end
			default: begin
			end
		endcase
		push_entry.status = final_status_n;
	end

	// A start pulse only comes with a good checksum.
	a_start_ok: assert property (@(posedge clk) disable iff (!arst_n)
		push && push_entry.start |-> push_entry.status == ST_OK && phase_q == PH_CHECK)
		else $error("start pulse without a matching checksum");

	// Stores happen only in the payload phase.
	a_we_payload: assert property (@(posedge clk) disable iff (!arst_n)
		push && push_entry.we |-> phase_q == PH_PAYLOAD && push_entry.status == ST_RECV)
		else $error("store outside the payload phase");

	// Once the frame has ended, the state machine never leaves the done phase.
	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DONE |=> phase_q == PH_DONE && $stable(final_status_q))
		else $error("frame state left the done phase");

endmodule

/* src/lpfl_queue.sv */
`timescale 1ns / 1ps
// Short queue between the front end and the back end.
// Depends on lpfl_pkg.
module lpfl_queue
	import lpfl_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  q_entry_t push_entry,
	output logic     full,
	input  logic     pop,
	output logic     pop_valid,
	output q_entry_t pop_entry
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	q_entry_t          mem_q [DEPTH];
	logic [PTR_W-1:0]  wptr_q, rptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_pop;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_entry = mem_q[rptr_q];
	assign do_pop    = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* src/lpfl_back.sv */
`timescale 1ns / 1ps
// Back end: forms the store address and holds the result in the output register.
// Depends on lpfl_pkg.
module lpfl_back
	import lpfl_pkg::*;
#(
	parameter int ADDR_BITS = ADDR_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_valid,
	input  q_entry_t               q_entry,
	output logic                   q_pop,
	input  logic [LOAD_BASE_W-1:0] load_base,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   write_enable,
	output logic [WADDR_W-1:0]     write_address,
	output logic [7:0]             write_data,
	output logic [1:0]             load_status,
	output logic                   start_program
);

	localparam logic [31:0] ADDR_MASK = 32'((64'd1 << ADDR_BITS) - 64'd1);

	logic        out_valid_q;
	logic [31:0] addr_sum;

	assign addr_sum  = (32'(load_base) + 32'(q_entry.index)) & ADDR_MASK;
	assign q_pop     = q_valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			write_enable  <= q_entry.we;
			write_address <= q_entry.we ? addr_sum[WADDR_W-1:0] : '0;
			write_data    <= q_entry.data;
			load_status   <= q_entry.status;
			start_program <= q_entry.start;
		end
	end

endmodule

/* src/length_prefixed_frame_loader.sv */
`timescale 1ns / 1ps
// Top level of the length-prefixed frame loader: configuration registers and wiring.
// Depends on lpfl_pkg, lpfl_front, lpfl_queue and lpfl_back.
//
// Usage: received bytes enter on the in_valid/in_ready channel, one per transaction.
// The first four bytes are a little-endian payload length, then come the payload
// bytes and one checksum byte (sum of the payload mod 256). Every input byte gives
// exactly one result transaction on out_valid/out_ready: a store request
// (write_enable, write_address, write_data) for payload bytes, the current
// load_status, and start_program on a matching checksum. Bytes after the end of a
// frame give results with no store and the final status.
// A result goes from the front end into the queue and then into the output register
// before it shows on out_valid. Throughput is one byte per cycle while the queue
// is not full: the front end updates the frame state on each accepted byte and a
// two-entry queue feeds the output register, so the input stays ready while a
// result waits. If the receiver stalls, the queue fills and in_ready drops once it
// holds two entries. Reset clears the frame state, empties the queue and restores
// the length limit to 88576 and load_base to 1024. The cfg_write port sets a
// register in the cycle it is high; cfg_index 0 is the length limit, 1 is load_base.
module length_prefixed_frame_loader
	import lpfl_pkg::*;
#(
	parameter int ADDR_BITS = ADDR_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_write,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [7:0]             rx_byte,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   write_enable,
	output logic [WADDR_W-1:0]     write_address,
	output logic [7:0]             write_data,
	output logic [1:0]             load_status,
	output logic                   start_program
);

	logic [LEN_LIMIT_W-1:0] len_limit_q;
	logic [LOAD_BASE_W-1:0] load_base_q;
	logic                   queue_full;
	logic                   push;
	q_entry_t               push_entry;
	logic                   q_valid;
	logic                   q_pop;
	q_entry_t               q_entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_limit_q <= LEN_LIMIT_RST;
			load_base_q <= LOAD_BASE_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_LEN_LIMIT: len_limit_q <= cfg_data[LEN_LIMIT_W-1:0];
				REG_LOAD_BASE: load_base_q <= cfg_data[LOAD_BASE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	lpfl_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.rx_byte    (rx_byte),
		.len_limit  (len_limit_q),
		.queue_full (queue_full),
		.push       (push),
		.push_entry (push_entry)
	);

	lpfl_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (queue_full),
		.pop        (q_pop),
		.pop_valid  (q_valid),
		.pop_entry  (q_entry)
	);

	lpfl_back #(
		.ADDR_BITS (ADDR_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_entry       (q_entry),
		.q_pop         (q_pop),
		.load_base     (load_base_q),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.write_enable  (write_enable),
		.write_address (write_address),
		.write_data    (write_data),
		.load_status   (load_status),
		.start_program (start_program)
	);

endmodule
